### rtl/core/msie_pkg.sv
// ----------------------------------------------------------------------------
// msie_pkg
// Shared types and constants for the instruction execute block: instruction
// kinds, field widths, register file geometry and the register write port.
// ----------------------------------------------------------------------------
package msie_pkg;

  // Register file geometry
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned REG_IDX_W = 5;
  localparam int unsigned DATA_W    = 32;

  // Link register used by jal
  localparam logic [REG_IDX_W-1:0] LINK_REG = 5'd31;

  // Program space: a power of two, so wrapping is a truncation
  localparam int unsigned PROGRAM_WORDS = 4096;
  localparam int unsigned PC_W          = $clog2(PROGRAM_WORDS);

  // Default data memory depth in words
  localparam int unsigned DATA_WORDS_DEF = 1024;

  // Field widths
  localparam int unsigned KIND_W   = 4;
  localparam int unsigned SHAMT_W  = 5;
  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned TARGET_W = 12;

  // Instruction kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD  = 4'd0,
    KIND_SUB  = 4'd1,
    KIND_LW   = 4'd2,
    KIND_SW   = 4'd3,
    KIND_SLL  = 4'd4,
    KIND_SRL  = 4'd5,
    KIND_BNE  = 4'd6,
    KIND_BEQ  = 4'd7,
    KIND_BLEZ = 4'd8,
    KIND_BGTZ = 4'd9,
    KIND_J    = 4'd10,
    KIND_JR   = 4'd11,
    KIND_JAL  = 4'd12
  } kind_t;

  // Register file write port
  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    data;
  } rf_wr_t;

endpackage : msie_pkg

### rtl/core/mips_subset_instruction_execute.sv
// Flow: an instruction passes from the operand register to the result register
// once that is free or being emptied. Throughput: one instruction per cycle while
// out_tready holds, set by the single execute pass between the two registers.
// Reset: register file and program counter read as zero at once; the data memory
// is cleared by a pass over all DATA_WORDS words, during which in_tready is low.
// ----------------------------------------------------------------------------
// mips_subset_instruction_execute
// Executes one decoded instruction per transfer against a register file, a
// program counter and a word data memory, and reports the next program
// counter, any register write, the branch outcome and any address fault.
// ----------------------------------------------------------------------------
module mips_subset_instruction_execute #(
  parameter int unsigned DATA_WORDS = msie_pkg::DATA_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Instruction channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: first_reg[4:0], second_reg[9:5], third_reg[14:10],
  //        shift_amount[19:15], offset[35:20], target[47:36]
  input  logic [47:0] in_tdata,
  // tuser: kind[3:0]
  input  logic [3:0]  in_tuser,
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: next_pc[11:0], reg_written[12], written_index[17:13],
  //        written_value[49:18], branch_taken[50], address_fault[51], zero[55:52]
  output logic [55:0] out_tdata
);
  import msie_pkg::*;

  localparam int unsigned AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

  // Handshake
  logic in_fire;
  logic exec_fire;

  // Operand stage
  logic                 s1_valid_r;
  logic [KIND_W-1:0]    s1_kind_r;
  logic [REG_IDX_W-1:0] s1_r1_r;
  logic [REG_IDX_W-1:0] s1_r2_r;
  logic [REG_IDX_W-1:0] s1_r3_r;
  logic [SHAMT_W-1:0]   s1_shamt_r;
  logic [OFFSET_W-1:0]  s1_offset_r;
  logic [TARGET_W-1:0]  s1_target_r;

  // Register file read
  logic [REG_IDX_W-1:0] ra1;
  logic [REG_IDX_W-1:0] ra2;
  logic [REG_IDX_W-1:0] ra3;
  logic [DATA_W-1:0]    rq1;
  logic [DATA_W-1:0]    rq2;
  logic [DATA_W-1:0]    rq3;
  rf_wr_t               rf_wr;

  // Architectural and result state
  logic [PC_W-1:0]      pc_r;
  logic                 out_valid_r;
  logic [PC_W-1:0]      out_pc_r;
  logic                 out_wr_r;
  logic [REG_IDX_W-1:0] out_widx_r;
  logic [DATA_W-1:0]    out_wval_r;
  logic                 out_load_r;
  logic                 out_taken_r;
  logic                 out_fault_r;
  logic                 wb_pend_r;
  logic [DATA_W-1:0]    wb_data;

  // Data memory
  logic [DATA_W-1:0]    dmem [DATA_WORDS];
  logic [DATA_W-1:0]    dmem_q_r;
  logic                 clr_busy_r;
  logic [AW-1:0]        clr_cnt_r;

  // Execute results
  logic [DATA_W-1:0]    op_a;
  logic [DATA_W-1:0]    op_b;
  logic [DATA_W-1:0]    op_c;
  logic [DATA_W:0]      addr;
  logic                 addr_bad;
  logic [PC_W-1:0]      pc_seq;
  logic [PC_W-1:0]      ex_pc;
  logic                 ex_wr;
  logic [DATA_W-1:0]    ex_wval;
  logic                 ex_taken;
  logic                 ex_fault;
  logic                 ex_load;
  logic                 ex_store;

  // ------------------------------------------------------------------------
  // Handshake: the operand stage moves on whenever the result register is
  // free or being emptied; nothing enters while the memory is being cleared.
  // ------------------------------------------------------------------------
  assign exec_fire = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clr_busy_r && (!s1_valid_r || exec_fire);
  assign in_fire   = in_tvalid && in_tready;

  // Operand stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (exec_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r   <= in_tuser;
      s1_r1_r     <= in_tdata[4:0];
      s1_r2_r     <= in_tdata[9:5];
      s1_r3_r     <= in_tdata[14:10];
      s1_shamt_r  <= in_tdata[19:15];
      s1_offset_r <= in_tdata[35:20];
      s1_target_r <= in_tdata[47:36];
    end
  end

  // ------------------------------------------------------------------------
  // Register file: three copies, one per operand. Each copy re-reads the
  // held index every cycle so that a waiting instruction sees later writes.
  // ------------------------------------------------------------------------
  assign ra1 = in_fire ? in_tdata[4:0]   : s1_r1_r;
  assign ra2 = in_fire ? in_tdata[9:5]   : s1_r2_r;
  assign ra3 = in_fire ? in_tdata[14:10] : s1_r3_r;

  // Write-back happens in the cycle after execute, once load data is known
  assign wb_data     = out_load_r ? dmem_q_r : out_wval_r;
  assign rf_wr.en    = wb_pend_r;
  assign rf_wr.idx   = out_widx_r;
  assign rf_wr.data  = wb_data;

  msie_rf_bank u_rf_a (.clk(clk), .rst_n(rst_n), .wr(rf_wr), .rd_idx(ra1), .rd_data(rq1));
  msie_rf_bank u_rf_b (.clk(clk), .rst_n(rst_n), .wr(rf_wr), .rd_idx(ra2), .rd_data(rq2));
  msie_rf_bank u_rf_c (.clk(clk), .rst_n(rst_n), .wr(rf_wr), .rd_idx(ra3), .rd_data(rq3));

  // Forward the pending write of the previous instruction into the operands
  assign op_a = (wb_pend_r && (out_widx_r == s1_r1_r)) ? wb_data : rq1;
  assign op_b = (wb_pend_r && (out_widx_r == s1_r2_r)) ? wb_data : rq2;
  assign op_c = (wb_pend_r && (out_widx_r == s1_r3_r)) ? wb_data : rq3;

  // ------------------------------------------------------------------------
  // Execute: address check, arithmetic and next program counter.
  // ------------------------------------------------------------------------
  assign addr     = {op_b[DATA_W-1], op_b}
                  + {{(DATA_W + 1 - OFFSET_W){s1_offset_r[OFFSET_W-1]}}, s1_offset_r};
  assign addr_bad = addr[DATA_W] || (addr >= (DATA_W + 1)'(DATA_WORDS));
  assign pc_seq   = pc_r + PC_W'(1);

  always_comb begin
    logic wr_req;
    wr_req   = 1'b0;
    ex_wval  = '0;
    ex_taken = 1'b0;
    ex_fault = 1'b0;
    ex_load  = 1'b0;
    ex_store = 1'b0;
    ex_pc    = pc_seq;
    case (s1_kind_r)
      KIND_ADD: begin
        wr_req  = 1'b1;
        ex_wval = op_b + op_c;
      end
      KIND_SUB: begin
        wr_req  = 1'b1;
        ex_wval = op_b - op_c;
      end
      KIND_LW: begin
        ex_fault = addr_bad;
        ex_load  = !addr_bad;
        wr_req   = !addr_bad;
      end
      KIND_SW: begin
        ex_fault = addr_bad;
        ex_store = !addr_bad;
      end
      KIND_SLL: begin
        wr_req  = 1'b1;
        ex_wval = op_b << s1_shamt_r;
      end
      KIND_SRL: begin
        wr_req  = 1'b1;
        ex_wval = op_b >> s1_shamt_r;
      end
      KIND_BNE:  ex_taken = (op_a != op_b);
      KIND_BEQ:  ex_taken = (op_a == op_b);
      KIND_BLEZ: ex_taken = op_a[DATA_W-1] || (op_a == '0);
      KIND_BGTZ: ex_taken = !op_a[DATA_W-1] && (op_a != '0);
      KIND_J:    ex_taken = 1'b1;
      KIND_JR:   ex_taken = 1'b1;
      KIND_JAL: begin
        ex_taken = 1'b1;
        wr_req   = 1'b1;
        ex_wval  = DATA_W'(pc_seq);
      end
      default: ;
    endcase

    // Jump and branch targets, wrapped to the program space
    if (ex_taken) begin
      if (s1_kind_r == KIND_JR) begin
        ex_pc = op_a[PC_W-1:0];
      end else begin
        ex_pc = s1_target_r[PC_W-1:0];
      end
    end

    // A write to register zero is dropped and reported as no write
    ex_wr = wr_req && (s1_kind_r == KIND_JAL || s1_r1_r != '0);
    if (!ex_wr) begin
      ex_wval = '0;
      ex_load = 1'b0;
    end
  end

  // Program counter and write-back marker
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= '0;
      wb_pend_r <= 1'b0;
    end else begin
      wb_pend_r <= exec_fire && ex_wr;
      if (exec_fire) begin
        pc_r <= ex_pc;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Result register
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_pc_r    <= ex_pc;
      out_wr_r    <= ex_wr;
      out_widx_r  <= ex_wr ? ((s1_kind_r == KIND_JAL) ? LINK_REG : s1_r1_r) : '0;
      out_wval_r  <= ex_wval;
      out_load_r  <= ex_load;
      out_taken_r <= ex_taken;
      out_fault_r <= ex_fault;
    end
  end

  // ------------------------------------------------------------------------
  // Data memory: clearing pass after reset, then at most one access per instruction.
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(DATA_WORDS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      dmem[clr_cnt_r] <= '0;
    end else if (exec_fire && ex_store) begin
      dmem[addr[AW-1:0]] <= op_a;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire && ex_load) begin
      dmem_q_r <= dmem[addr[AW-1:0]];
    end
  end

  // Output packing
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_fault_r, out_taken_r, wb_data, out_widx_r,
                       out_wr_r, out_pc_r};

endmodule : mips_subset_instruction_execute

### rtl/core/msie_rf_bank.sv
// ----------------------------------------------------------------------------
// msie_rf_bank
// One copy of the register file with a single registered read port and a
// single write port. A read at the address being written returns the new
// data. Entries that were never written since reset read as zero.
// ----------------------------------------------------------------------------
module msie_rf_bank (
  input  logic                               clk,
  input  logic                               rst_n,
  input  msie_pkg::rf_wr_t                   wr,
  input  logic [msie_pkg::REG_IDX_W-1:0]     rd_idx,
  output logic [msie_pkg::DATA_W-1:0]        rd_data
);
  import msie_pkg::*;

  logic [DATA_W-1:0]    mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid_r;
  logic [DATA_W-1:0]    rd_data_r;

  // Valid bits: cleared by reset, set on the first write of each entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.idx] <= 1'b1;
    end
  end

  // Storage write
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
  end

  // Registered read with write-first bypass
  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == rd_idx)) begin
      rd_data_r <= wr.data;
    end else if (valid_r[rd_idx]) begin
      rd_data_r <= mem[rd_idx];
    end else begin
      rd_data_r <= '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule : msie_rf_bank

### tb/tb_mips_subset_instruction_execute.sv
// ----------------------------------------------------------------------------
// tb_mips_subset_instruction_execute
// Self-checking bench for the instruction execute block. Directed instruction
// sequences cover the arithmetic, memory and control-flow corner cases. A long
// random program follows, with loads and stores steered mostly into the data
// memory. The bench keeps its own register file, program counter and data
// memory, predicts every result at the input transfer and compares each
// output transfer field by field. The sender pauses in bursts, the receiver
// stalls on its own pattern, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_mips_subset_instruction_execute;
  import msie_pkg::*;

  localparam int unsigned DMEM_WORDS     = DATA_WORDS_DEF;
  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PRESSURE_ITEMS = 64;
  localparam int unsigned RANDOM_ITEMS   = 1560;
  localparam int unsigned MAX_REPORTS    = 10;

  // Kind codes outside the instruction set; the block treats them as no-ops
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 4'd13;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 4'd15;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_t;

  // One executed instruction as seen on the result channel
  typedef struct packed {
    logic [PC_W-1:0]      next_pc;
    logic                 wr;
    logic [REG_IDX_W-1:0] widx;
    logic [DATA_W-1:0]    wval;
    logic                 taken;
    logic                 fault;
  } exec_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic [3:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  // Predicted architectural state
  logic [DATA_W-1:0] gpr [REG_COUNT];
  logic [DATA_W-1:0] dmem [DMEM_WORDS];
  logic [PC_W-1:0]   pc;

  exec_result_t pending_results [$];
  int unsigned  mismatch_count = 0;
  int unsigned  burst_left     = 0;
  bit           pacing_on      = 1'b1;
  bit           hold_request   = 1'b0;

  mips_subset_instruction_execute #(
    .DATA_WORDS(DMEM_WORDS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #10 clk = ~clk;

  // Reset state of the predicted machine.
  initial begin
    for (int i = 0; i < REG_COUNT; i++) gpr[i] = '0;
    for (int i = 0; i < DMEM_WORDS; i++) dmem[i] = '0;
    pc = '0;
  end

  function automatic logic [47:0] pack_instr(logic [4:0] r1, logic [4:0] r2,
                                              logic [4:0] r3, logic [4:0] sh,
                                              logic [15:0] off, logic [11:0] tgt);
    return {tgt, off, sh, r3, r2, r1};
  endfunction

  // Executes one instruction on the predicted state and queues its result.
  task automatic execute_instr(input logic [3:0] k, input logic [47:0] d);
    logic [4:0]         r1, r2, r3, sh;
    logic signed [15:0] off;
    logic [11:0]        tgt;
    logic [DATA_W-1:0]  a, b;
    longint             addr;
    exec_result_t       res;
    r1  = d[4:0];
    r2  = d[9:5];
    r3  = d[14:10];
    sh  = d[19:15];
    off = d[35:20];
    tgt = d[47:36];
    a   = gpr[r1];
    b   = gpr[r2];
    res = '0;
    res.next_pc = pc + 1'b1;
    case (k)
      KIND_ADD: begin
        res.wr = 1'b1; res.widx = r1; res.wval = b + gpr[r3];
      end
      KIND_SUB: begin
        res.wr = 1'b1; res.widx = r1; res.wval = b - gpr[r3];
      end
      KIND_LW, KIND_SW: begin
        addr = longint'($signed(b)) + longint'(off);
        if (addr < 0 || addr >= DMEM_WORDS) begin
          res.fault = 1'b1;
        end else if (k == KIND_LW) begin
          res.wr = 1'b1; res.widx = r1; res.wval = dmem[int'(addr)];
        end else begin
          dmem[int'(addr)] = a;
        end
      end
      KIND_SLL: begin
        res.wr = 1'b1; res.widx = r1; res.wval = b << sh;
      end
      KIND_SRL: begin
        res.wr = 1'b1; res.widx = r1; res.wval = b >> sh;
      end
      KIND_BNE:  res.taken = (a != b);
      KIND_BEQ:  res.taken = (a == b);
      KIND_BLEZ: res.taken = ($signed(a) <= 0);
      KIND_BGTZ: res.taken = ($signed(a) > 0);
      KIND_J, KIND_JR: res.taken = 1'b1;
      KIND_JAL: begin
        res.wr = 1'b1; res.widx = LINK_REG; res.wval = {20'd0, res.next_pc};
        res.taken = 1'b1;
      end
      default: ;
    endcase
    // The program space is a power of two, so wrapping keeps the low bits.
    if (res.taken) res.next_pc = (k == KIND_JR) ? a[PC_W-1:0] : tgt;
    if (res.wr && res.widx == '0) res.wr = 1'b0;
    if (res.wr) begin
      gpr[res.widx] = res.wval;
    end else begin
      res.widx = '0;
      res.wval = '0;
    end
    pc = res.next_pc;
    pending_results.push_back(res);
  endtask

  // Offers one instruction until it is transferred, then pauses as the burst
  // pattern asks.
  task automatic send_instr(input logic [3:0] k, input logic [47:0] d);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    execute_instr(k, d);
    if (pacing_on) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 24);
        repeat ($urandom_range(1, 12)) begin
          @(negedge clk);
          in_tvalid <= 1'b0;
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  // Draws one instruction. Most loads and stores are steered into the data
  // memory using the predicted base register; the rest keep random offsets.
  task automatic pick_random_instr(output logic [3:0] k, output logic [47:0] d);
    int unsigned pick;
    logic [4:0]  r1, r2, r3, sh;
    logic [15:0] off;
    logic [11:0] tgt;
    longint      want, delta;
    pick = $urandom_range(0, 31);
    if (pick <= KIND_JAL)  k = pick[3:0];
    else if (pick < 18)    k = KIND_LW;
    else if (pick < 23)    k = KIND_SW;
    else if (pick < 26)    k = KIND_ADD;
    else if (pick < 28)    k = KIND_JAL;
    else if (pick < 30)    k = KIND_SUB;
    else                   k = 4'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    r1  = 5'($urandom_range(0, 31));
    r2  = 5'($urandom_range(0, 31));
    r3  = 5'($urandom_range(0, 31));
    sh  = 5'($urandom_range(0, 31));
    off = 16'($urandom_range(0, 16'hffff));
    tgt = 12'($urandom_range(0, 12'hfff));
    // Equal compare operands now and then, so both branch outcomes occur.
    if ($urandom_range(0, 3) == 0) r2 = r1;
    if ((k == KIND_LW || k == KIND_SW) && $urandom_range(0, 4) != 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: want = longint'($urandom_range(0, 15));
        5, 6, 7, 8:    want = longint'($urandom_range(0, DMEM_WORDS - 1));
        default:       want = $urandom_range(0, 1) ? longint'(DMEM_WORDS - 1) : 64'sd0;
      endcase
      delta = want - longint'($signed(gpr[r2]));
      if (delta < -32768 || delta > 32767) begin
        r2    = '0;
        delta = want;
      end
      off = delta[15:0];
    end
    d = pack_instr(r1, r2, r3, sh, off, tgt);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("mismatch in %s: expected %h, got %h", name, exp_v, act_v);
    end
  endtask

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    exec_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result transfer: %h", out_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("next_pc",       32'(want.next_pc), 32'(out_tdata[11:0]));
        check_field("reg_written",   32'(want.wr),      32'(out_tdata[12]));
        check_field("written_index", 32'(want.widx),    32'(out_tdata[17:13]));
        check_field("written_value", want.wval,         out_tdata[49:18]);
        check_field("branch_taken",  32'(want.taken),   32'(out_tdata[50]));
        check_field("address_fault", 32'(want.fault),   32'(out_tdata[51]));
        check_field("padding",       32'd0,             32'(out_tdata[55:52]));
      end
    end
  end

  // Receiver: switches between stall patterns, and holds off for a long
  // stretch once asked to.
  initial begin : receiver
    rx_mode_t    mode;
    int unsigned mode_left;
    mode      = RX_OPEN;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        for (int n = 1; n < HOLD_CYCLES; n++) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(32, 200);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_tready <= ($urandom_range(0, 4) == 0);
          default:   out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Arithmetic and shifts. Jumps first load the link register: the wrap of pc + 1
  // to zero at the top of program space, then a non-zero value.
  task automatic test_alu_ops();
    send_instr(KIND_J,    pack_instr(0, 0, 0, 0, 16'h0000, 12'd4095));
    send_instr(KIND_JAL,  pack_instr(0, 0, 0, 0, 16'h0000, 12'd4000));
    send_instr(KIND_JAL,  pack_instr(0, 0, 0, 0, 16'h0000, 12'd12));
    send_instr(KIND_ADD,  pack_instr(1, 31, 31, 0, 16'h0000, 12'd0));
    send_instr(KIND_SUB,  pack_instr(2, 0, 31, 0, 16'h0000, 12'd0));
    send_instr(KIND_SLL,  pack_instr(3, 31, 0, 31, 16'h0000, 12'd0));
    // A logical shift of the sign bit leaves a single one.
    send_instr(KIND_SRL,  pack_instr(4, 3, 0, 31, 16'h0000, 12'd0));
    send_instr(KIND_SRL,  pack_instr(6, 2, 0, 0, 16'h0000, 12'd0));
    // Writes to register zero are discarded.
    send_instr(KIND_ADD,  pack_instr(0, 31, 31, 0, 16'h0000, 12'd0));
  endtask

  // Loads and stores at the memory edges, base plus offset, and faults.
  task automatic test_memory_access();
    send_instr(KIND_SW, pack_instr(31, 0, 0, 0, 16'd1023, 12'd0));
    send_instr(KIND_LW, pack_instr(10, 0, 0, 0, 16'd1023, 12'd0));
    send_instr(KIND_LW, pack_instr(12, 0, 0, 0, 16'h8000, 12'd0));
    send_instr(KIND_SW, pack_instr(1, 0, 0, 0, 16'h7fff, 12'd0));
    send_instr(KIND_LW, pack_instr(12, 0, 0, 0, 16'd1024, 12'd0));
    send_instr(KIND_LW, pack_instr(0, 31, 0, 0, -16'sd4001, 12'd0));
  endtask

  // Branches both ways, signed compares, jr wrap and unused kinds.
  task automatic test_control_flow();
    send_instr(KIND_BEQ,       pack_instr(0, 0, 0, 0, 16'h0000, 12'd77));
    send_instr(KIND_BNE,       pack_instr(1, 2, 0, 0, 16'h0000, 12'd3000));
    send_instr(KIND_BEQ,       pack_instr(1, 2, 0, 0, 16'h0000, 12'd5));
    send_instr(KIND_BLEZ,      pack_instr(2, 0, 0, 0, 16'h0000, 12'd200));
    send_instr(KIND_BGTZ,      pack_instr(1, 0, 0, 0, 16'h0000, 12'd0));
    send_instr(KIND_BGTZ,      pack_instr(3, 0, 0, 0, 16'h0000, 12'd9));
    send_instr(KIND_JR,        pack_instr(2, 0, 0, 0, 16'h0000, 12'd0));
    send_instr(KIND_UNUSED_LO, pack_instr(31, 31, 31, 31, 16'hffff, 12'hfff));
    send_instr(KIND_UNUSED_HI, pack_instr(1, 2, 3, 4, 16'h1234, 12'h567));
  endtask

  // The receiver holds off while items are offered back to back.
  task automatic test_output_backpressure();
    logic [3:0]  k;
    logic [47:0] d;
    pacing_on    = 1'b0;
    hold_request = 1'b1;
    repeat (PRESSURE_ITEMS) begin
      pick_random_instr(k, d);
      send_instr(k, d);
    end
    pacing_on = 1'b1;
  endtask

  task automatic test_random_program();
    logic [3:0]  k;
    logic [47:0] d;
    repeat (RANDOM_ITEMS) begin
      pick_random_instr(k, d);
      send_instr(k, d);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_alu_ops();
    test_memory_access();
    test_control_flow();
    test_output_backpressure();
    test_random_program();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

endmodule
